// ----- sv/sc2p_pkg.sv -----
// Shared widths, constants and types for the sphere-to-cube point pipeline.
package sc2p_pkg;

  // Fixed-point format of the ports and the derived internal widths.
  localparam int FRAC_BITS = 16;
  localparam int IO_W      = FRAC_BITS + 2;
  localparam int MAG_W     = FRAC_BITS + 1;
  localparam int SQ_W      = 2 * FRAC_BITS + 4;
  localparam int ROOT_W    = SQ_W / 2;
  localparam int RS_W      = ROOT_W + 1;
  localparam int DIFF_W    = 2 * FRAC_BITS + 2;

  // Square root unit: digits resolved per register stage and stage count.
  localparam int SQ_STEPS  = 3;
  localparam int SQ_STAGES = (ROOT_W + SQ_STEPS - 1) / SQ_STEPS;

  // Cycles from the radicand leaving the front end to the result strobe.
  localparam int BACK_LAT  = 2 * SQ_STAGES + 2;

  localparam logic [MAG_W-1:0]         ONE_MAG    = MAG_W'(1) << FRAC_BITS;
  localparam logic [ROOT_W-1:0]        ONE_ROOT   = ROOT_W'(1) << FRAC_BITS;
  localparam logic signed [IO_W-1:0]   ONE_IO     = IO_W'(1) << FRAC_BITS;
  localparam logic signed [IO_W-1:0]   NEG_ONE_IO = -(IO_W'(1) << FRAC_BITS);

  // Which input axis was rotated into z.
  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  // Data that travels alongside a radicand through the square root units.
  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic                     sign_u;
    logic                     sign_v;
    logic                     sign_w;
    axis_e                    axis;
  } side_t;

endpackage

// ----- sv/sc2p_sqrt.sv -----
// Pipelined integer square root, a few result digits per register stage.
module sc2p_sqrt import sc2p_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [SQ_W-1:0]   rad_i,
  input  side_t             side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output side_t             side_o
);

  logic              valid_q [SQ_STAGES];
  logic [SQ_W-1:0]   rad_q   [SQ_STAGES];
  logic [RS_W-1:0]   rem_q   [SQ_STAGES];
  logic [ROOT_W-1:0] root_q  [SQ_STAGES];
  side_t             side_q  [SQ_STAGES];

  logic              src_valid [SQ_STAGES];
  logic [SQ_W-1:0]   src_rad   [SQ_STAGES];
  logic [RS_W-1:0]   src_rem   [SQ_STAGES];
  logic [ROOT_W-1:0] src_root  [SQ_STAGES];
  side_t             src_side  [SQ_STAGES];

  logic [SQ_W-1:0]   rad_d  [SQ_STAGES];
  logic [RS_W-1:0]   rem_d  [SQ_STAGES];
  logic [ROOT_W-1:0] root_d [SQ_STAGES];

  // Each stage takes its operands from the stage before it.
  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_src
    if (g == 0) begin : g_first
      assign src_valid[g] = valid_i;
      assign src_rad[g]   = rad_i;
      assign src_rem[g]   = '0;
      assign src_root[g]  = '0;
      assign src_side[g]  = side_i;
    end else begin : g_next
      assign src_valid[g] = valid_q[g-1];
      assign src_rad[g]   = rad_q[g-1];
      assign src_rem[g]   = rem_q[g-1];
      assign src_root[g]  = root_q[g-1];
      assign src_side[g]  = side_q[g-1];
    end
  end

  // Restoring digit recurrence: two radicand bits in, one root bit out per step.
  always_comb begin
    logic [SQ_W-1:0]   rad;
    logic [RS_W+1:0]   rem;
    logic [RS_W+1:0]   trial;
    logic [ROOT_W-1:0] root;
    for (int g = 0; g < SQ_STAGES; g++) begin
      rad  = src_rad[g];
      rem  = (RS_W + 2)'(src_rem[g]);
      root = src_root[g];
      for (int k = 0; k < SQ_STEPS; k++) begin
        if (g * SQ_STEPS + k < ROOT_W) begin
          rem   = {rem[RS_W-1:0], rad[SQ_W-1:SQ_W-2]};
          rad   = rad << 2;
          trial = (RS_W + 2)'({root, 2'b01});
          if (rem >= trial) begin
            rem  = rem - trial;
            root = {root[ROOT_W-2:0], 1'b1};
          end else begin
            root = {root[ROOT_W-2:0], 1'b0};
          end
        end
      end
      rad_d[g]  = rad;
      rem_d[g]  = rem[RS_W-1:0];
      root_d[g] = root;
    end
  end

  // Valid bits are cleared by reset; the payload is only loaded with an item.
  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else begin
        valid_q[g] <= src_valid[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (src_valid[g]) begin
        rad_q[g]  <= rad_d[g];
        rem_q[g]  <= rem_d[g];
        root_q[g] <= root_d[g];
        side_q[g] <= src_side[g];
      end
    end
  end

  assign valid_o = valid_q[SQ_STAGES-1];
  assign root_o  = root_q[SQ_STAGES-1];
  assign side_o  = side_q[SQ_STAGES-1];

endmodule

// ----- sv/sc2p_front.sv -----
// Front end: axis choice, squares, difference term and the first radicand.
module sc2p_front import sc2p_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic signed [IO_W-1:0] point_x_i,
  input  logic signed [IO_W-1:0] point_y_i,
  input  logic signed [IO_W-1:0] point_z_i,
  output logic                   valid_o,
  output logic [SQ_W-1:0]        rad_o,
  output side_t                  side_o
);

  localparam int SUM_W = 2 * FRAC_BITS + 2;
  localparam int SQR_W = 2 * FRAC_BITS + 1;
  localparam int R_W   = 2 * FRAC_BITS + 5;
  localparam logic signed [R_W-1:0] NINE_Q = R_W'(9) << (2 * FRAC_BITS - 2);

  logic [4:0] valid_q;

  // Stage one: magnitudes, major axis and rotation of the minor components.
  logic [IO_W-1:0]  ax, ay, az, mu, mv;
  logic             su, sv, sw;
  axis_e            axis_d;
  logic [MAG_W-1:0] au_q, av_q;
  side_t            side1_q;

  always_comb begin
    ax = point_x_i[IO_W-1] ? (~point_x_i + 1'b1) : point_x_i;
    ay = point_y_i[IO_W-1] ? (~point_y_i + 1'b1) : point_y_i;
    az = point_z_i[IO_W-1] ? (~point_z_i + 1'b1) : point_z_i;
    if (ay >= ax && ay >= az) begin
      axis_d = AXIS_Y;
      mu = ax; mv = az;
      su = point_x_i[IO_W-1]; sv = point_z_i[IO_W-1]; sw = point_y_i[IO_W-1];
    end else if (ax >= az) begin
      axis_d = AXIS_X;
      mu = ay; mv = az;
      su = point_y_i[IO_W-1]; sv = point_z_i[IO_W-1]; sw = point_x_i[IO_W-1];
    end else begin
      axis_d = AXIS_Z;
      mu = ax; mv = ay;
      su = point_x_i[IO_W-1]; sv = point_y_i[IO_W-1]; sw = point_z_i[IO_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      au_q           <= (mu > IO_W'(ONE_MAG)) ? ONE_MAG : mu[MAG_W-1:0];
      av_q           <= (mv > IO_W'(ONE_MAG)) ? ONE_MAG : mv[MAG_W-1:0];
      side1_q.diff   <= '0;
      side1_q.sign_u <= su;
      side1_q.sign_v <= sv;
      side1_q.sign_w <= sw;
      side1_q.axis   <= axis_d;
    end
  end

  // Stage two: squares of the saturated minor magnitudes.
  logic [2*MAG_W-1:0] pa, pb;
  logic [SQR_W-1:0]   a_q, b_q;
  side_t              side2_q;

  assign pa = au_q * au_q;
  assign pb = av_q * av_q;

  always_ff @(posedge clk_i) begin
    if (valid_q[0]) begin
      a_q     <= pa[SQR_W-1:0];
      b_q     <= pb[SQR_W-1:0];
      side2_q <= side1_q;
    end
  end

  // Stage three: signed difference, its magnitude and the sum.
  logic signed [DIFF_W-1:0] diff;
  logic [SQR_W-1:0]         d_q;
  logic [SUM_W-1:0]         sum_q;
  side_t                    side3_d;
  side_t                    side3_q;

  assign diff = signed'({1'b0, a_q}) - signed'({1'b0, b_q});

  // The side data picks up the signed difference here.
  always_comb begin
    side3_d      = side2_q;
    side3_d.diff = diff;
  end

  always_ff @(posedge clk_i) begin
    if (valid_q[1]) begin
      d_q     <= diff[DIFF_W-1] ? SQR_W'(-diff) : SQR_W'(diff);
      sum_q   <= SUM_W'(a_q) + SUM_W'(b_q);
      side3_q <= side3_d;
    end
  end

  // Stage four: square of the difference, scaled back to the square format.
  logic [2*SQR_W-1:0] dd;
  logic [SQR_W-1:0]   d2_q;
  logic [SUM_W-1:0]   sum4_q;
  side_t              side4_q;

  assign dd = d_q * d_q;

  always_ff @(posedge clk_i) begin
    if (valid_q[2]) begin
      d2_q    <= dd[4*FRAC_BITS:2*FRAC_BITS];
      sum4_q  <= sum_q;
      side4_q <= side3_q;
    end
  end

  // Stage five: quarter radicand, clamped at zero, then scaled by four.
  logic signed [R_W-1:0] r4;

  assign r4 = signed'(R_W'(d2_q)) - signed'(R_W'(3) * R_W'(sum4_q)) + NINE_Q;

  always_ff @(posedge clk_i) begin
    if (valid_q[3]) begin
      rad_o  <= r4[R_W-1] ? '0 : {r4[2*FRAC_BITS+1:0], 2'b00};
      side_o <= side4_q;
    end
  end

  // Valid bits for the five stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[3:0], valid_i};
    end
  end

  assign valid_o = valid_q[4];

endmodule

// ----- sv/sc2p_back.sv -----
// Back end: minor radicands, their square roots, saturation and un-rotation.
module sc2p_back import sc2p_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [ROOT_W-1:0]      root_i,
  input  side_t                  side_i,
  output logic                   done_o,
  output logic signed [IO_W-1:0] cube_x_o,
  output logic signed [IO_W-1:0] cube_y_o,
  output logic signed [IO_W-1:0] cube_z_o
);

  localparam int S_W = ROOT_W + 2;
  localparam logic signed [S_W-1:0] THREE_Q = S_W'(3) << FRAC_BITS;

  // Radicands for the two minor components, halved by the shift of s.
  logic signed [S_W-1:0]  s;
  logic signed [SQ_W-1:0] hs, dx, hu, hv;
  logic                   rv_q;
  logic [SQ_W-1:0]        radu_q, radv_q;
  side_t                  side_q;

  always_comb begin
    s  = THREE_Q - signed'({2'b00, root_i});
    hs = signed'(SQ_W'(s)) <<< (FRAC_BITS - 1);
    dx = SQ_W'(side_i.diff);
    hu = hs + dx;
    hv = hs - dx;
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      radu_q <= (hu > 0) ? hu : '0;
      radv_q <= (hv > 0) ? hv : '0;
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= valid_i;
    end
  end

  // Two square root lanes side by side.
  logic              vu, vv;
  logic [ROOT_W-1:0] ru, rv;
  side_t             su, sv;

  sc2p_sqrt u_sqrt_u (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rv_q),
    .rad_i   (radu_q),
    .side_i  (side_q),
    .valid_o (vu),
    .root_o  (ru),
    .side_o  (su)
  );

  sc2p_sqrt u_sqrt_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rv_q),
    .rad_i   (radv_q),
    .side_i  (side_q),
    .valid_o (vv),
    .root_o  (rv),
    .side_o  (sv)
  );

  // Saturate to one, apply the input signs and undo the rotation.
  logic [IO_W-1:0]        mu, mv;
  logic signed [IO_W-1:0] cu, cv, cw, ox, oy, oz;

  always_comb begin
    mu = IO_W'((ru > ONE_ROOT) ? ONE_ROOT : ru);
    mv = IO_W'((rv > ONE_ROOT) ? ONE_ROOT : rv);
    cu = su.sign_u ? -signed'(mu) : signed'(mu);
    cv = sv.sign_v ? -signed'(mv) : signed'(mv);
    cw = su.sign_w ? NEG_ONE_IO : ONE_IO;
    case (su.axis)
      AXIS_Y: begin
        ox = cu; oy = cw; oz = cv;
      end
      AXIS_X: begin
        ox = cw; oy = cu; oz = cv;
      end
      default: begin
        ox = cu; oy = cv; oz = cw;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (vu) begin
      cube_x_o <= ox;
      cube_y_o <= oy;
      cube_z_o <= oz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= vu & vv;
    end
  end

endmodule

// ----- sv/sphere_to_cube_point.sv -----
// Top level of the sphere-to-cube point mapper.
//
//   channel | handshake        | payload
//   --------+------------------+-----------------------------------------
//   input   | start_i, busy_o  | point_x_i, point_y_i, point_z_i (Q1.16)
//   result  | done_o (strobe)  | cube_x_o, cube_y_o, cube_z_o (Q1.16)
//
// One item enters per cycle; busy_o is never raised.
// Each result passes through five front-end stages, two six-stage square
// root units in series and two back-end registers.
// The square root units resolve three result digits per stage.
// Reset clears only the valid bits; items in flight are dropped.
// The receiver cannot stall, so nothing inside ever holds.
module sphere_to_cube_point import sc2p_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic signed [IO_W-1:0] point_x_i,
  input  logic signed [IO_W-1:0] point_y_i,
  input  logic signed [IO_W-1:0] point_z_i,
  output logic                   done_o,
  output logic signed [IO_W-1:0] cube_x_o,
  output logic signed [IO_W-1:0] cube_y_o,
  output logic signed [IO_W-1:0] cube_z_o
);

  logic              fv, sqv;
  logic [SQ_W-1:0]   frad;
  side_t             fside, sqside;
  logic [ROOT_W-1:0] sqroot;

  // The pipeline never stalls.
  assign busy_o = 1'b0;

  sc2p_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start_i),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .point_z_i (point_z_i),
    .valid_o   (fv),
    .rad_o     (frad),
    .side_o    (fside)
  );

  // Square root of the combined radicand.
  sc2p_sqrt u_sqrt_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fv),
    .rad_i   (frad),
    .side_i  (fside),
    .valid_o (sqv),
    .root_o  (sqroot),
    .side_o  (sqside)
  );

  sc2p_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sqv),
    .root_i   (sqroot),
    .side_i   (sqside),
    .done_o   (done_o),
    .cube_x_o (cube_x_o),
    .cube_y_o (cube_y_o),
    .cube_z_o (cube_z_o)
  );

  // Every result lies within the unit cube.
  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (cube_x_o <= ONE_IO && cube_x_o >= NEG_ONE_IO &&
                cube_y_o <= ONE_IO && cube_y_o >= NEG_ONE_IO &&
                cube_z_o <= ONE_IO && cube_z_o >= NEG_ONE_IO))
    else $error("cube point outside the unit cube");

  // The major axis always ends on a face.
  a_face : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (cube_x_o == ONE_IO || cube_x_o == NEG_ONE_IO ||
                cube_y_o == ONE_IO || cube_y_o == NEG_ONE_IO ||
                cube_z_o == ONE_IO || cube_z_o == NEG_ONE_IO))
    else $error("cube point has no component on a face");

  // A result strobe follows a front-end item after the fixed back latency.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(fv, BACK_LAT))
    else $error("result strobe without a matching item");

endmodule
